>>> rtl/mba_pkg.sv
// ----------------------------------------------------------------------------
// Memory map bump allocator package
// Shared types and constants for the region table and the allocation walk.
// ----------------------------------------------------------------------------
package mba_pkg;

  localparam int ADDR_W   = 36;
  localparam int SIZE_W   = 32;
  localparam int CNT_W    = 5;
  localparam int IN_IDX_W = 4;
  localparam int PAGE_W   = 12;

  // 4 GiB, one past the highest byte that an allocation may reach.
  localparam logic [ADDR_W:0] LIMIT_32 = 37'h1_0000_0000;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_OOM    = 2'd1,
    ST_LIMIT  = 2'd2,
    ST_LOADED = 2'd3
  } status_t;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_ALLOC = 1'b1
  } req_t;

  typedef enum logic [2:0] {
    S_IDLE     = 3'd0,
    S_BACK     = 3'd1,
    S_FWD_LIM  = 3'd2,
    S_FWD_FIT  = 3'd3,
    S_FWD_NEXT = 3'd4,
    S_DONE     = 3'd5
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] length;
  } region_t;

endpackage

>>> rtl/mba_region_ram.sv
// ----------------------------------------------------------------------------
// Region table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mba_region_ram #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [ADDR_W-1:0]  wr_addr,
  input  mba_pkg::region_t   wr_data,
  input  logic [ADDR_W-1:0]  rd_addr,
  output mba_pkg::region_t   rd_data
);

  mba_pkg::region_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/memory_map_bump_allocator.sv
// ----------------------------------------------------------------------------
// Memory map bump allocator
// Page-granular bump allocator over a table of usable memory regions.
// ----------------------------------------------------------------------------
// The block holds up to MAX_REGIONS regions (base and length) in a synchronous
// memory with registered read data. A load request (req_type 0) writes one
// entry and answers with status 3 through the done state and the output
// register. An allocate request (req_type 1) walks the table back from the
// last active region to the last one whose base is not above the start
// address, or to the first region, then walks forward, taking each region
// through limit check and page alignment, fit compare, and fetch of the
// next base. The region memory has a single read port. One request is in
// flight at a time, but a new request is taken as soon as the result has
// moved into the output register, even while that result is still stalled.
// Entries that were never loaded must not lie within region_count.
module memory_map_bump_allocator #(
  parameter int MAX_REGIONS = 16
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [3:0]  in_region_index,
  input  logic [35:0] in_region_base,
  input  logic [35:0] in_region_length,
  input  logic [35:0] in_start_address,
  input  logic [31:0] in_alloc_size,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [35:0] out_end_address,
  output logic [1:0]  out_status
);

  localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int AW    = mba_pkg::ADDR_W;
  localparam int SW    = mba_pkg::SIZE_W;
  localparam int CW    = mba_pkg::CNT_W;
  localparam int PW    = mba_pkg::PAGE_W;

  mba_pkg::state_t  state_r, state_nxt;

  logic [CW-1:0]    region_count_r;
  logic [CW-1:0]    e_r, e_nxt;
  logic [AW-1:0]    start_r, start_nxt;
  logic [SW-1:0]    size_r, size_nxt;
  logic [AW-1:0]    aligned_r, aligned_nxt;
  logic [AW:0]      region_end_r, region_end_nxt;
  logic [AW-1:0]    res_end_r, res_end_nxt;
  mba_pkg::status_t res_status_r, res_status_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [AW-1:0]    out_end_r, out_end_nxt;
  mba_pkg::status_t out_status_r, out_status_nxt;

  logic             in_acc;
  logic             load_hit;
  logic [CW-1:0]    active_cnt;
  logic [AW:0]      lim_sum;
  logic [AW:0]      fit_sum;
  logic [AW-1:0]    aligned_calc;
  logic             last_region;
  logic             out_free;
  mba_pkg::region_t wr_data;
  mba_pkg::region_t rd_data;

  assign in_stall = (state_r != mba_pkg::S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // A load into a slot beyond the table writes nothing but still answers.
  assign load_hit = (32'(in_region_index) < 32'(MAX_REGIONS));

  // A count above the table size acts as the table size.
  assign active_cnt = (32'(region_count_r) > 32'(MAX_REGIONS)) ?
                      CW'(MAX_REGIONS) : region_count_r;

  // Limit check on the unaligned start, then page alignment. Past the limit
  // check the start is at most 4 GiB, so alignment cannot overflow.
  assign lim_sum      = {1'b0, start_r} + {{(AW + 1 - SW){1'b0}}, size_r};
  assign aligned_calc = (start_r[PW-1:0] != '0) ?
                        {start_r[AW-1:PW] + (AW - PW)'(1), {PW{1'b0}}} : start_r;
  assign fit_sum      = {1'b0, aligned_r} + {{(AW + 1 - SW){1'b0}}, size_r};
  assign last_region  = (({1'b0, e_r} + (CW + 1)'(1)) >= {1'b0, active_cnt});

  assign out_free = !out_valid_r || !out_stall;

  assign wr_data.base   = in_region_base;
  assign wr_data.length = in_region_length;

  // The memory is read every cycle at the next walk index, so rd_data always
  // holds the entry at e_r.
  mba_region_ram #(
    .DEPTH  (MAX_REGIONS),
    .ADDR_W (IDX_W)
  ) u_region_ram (
    .clk     (clk),
    .wr_en   (in_acc && (in_req_type == mba_pkg::REQ_LOAD) && load_hit),
    .wr_addr (IDX_W'(in_region_index)),
    .wr_data (wr_data),
    .rd_addr (IDX_W'(e_nxt)),
    .rd_data (rd_data)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mba_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_req_type == mba_pkg::REQ_LOAD || active_cnt == '0) begin
            state_nxt = mba_pkg::S_DONE;
          end else begin
            state_nxt = mba_pkg::S_BACK;
          end
        end
      end
      mba_pkg::S_BACK: begin
        if (!(start_r < rd_data.base) || e_r == '0) begin
          state_nxt = mba_pkg::S_FWD_LIM;
        end
      end
      mba_pkg::S_FWD_LIM: begin
        if (lim_sum > mba_pkg::LIMIT_32) begin
          state_nxt = mba_pkg::S_DONE;
        end else begin
          state_nxt = mba_pkg::S_FWD_FIT;
        end
      end
      mba_pkg::S_FWD_FIT: begin
        if (fit_sum < region_end_r || last_region) begin
          state_nxt = mba_pkg::S_DONE;
        end else begin
          state_nxt = mba_pkg::S_FWD_NEXT;
        end
      end
      mba_pkg::S_FWD_NEXT: state_nxt = mba_pkg::S_FWD_LIM;
      mba_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = mba_pkg::S_IDLE;
        end
      end
      default: state_nxt = mba_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    e_nxt          = e_r;
    start_nxt      = start_r;
    size_nxt       = size_r;
    aligned_nxt    = aligned_r;
    region_end_nxt = region_end_r;
    res_end_nxt    = res_end_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_end_nxt    = out_end_r;
    out_status_nxt = out_status_r;
    case (state_r)
      mba_pkg::S_IDLE: begin
        if (in_acc) begin
          res_end_nxt = '0;
          start_nxt   = in_start_address;
          size_nxt    = in_alloc_size;
          e_nxt       = active_cnt - CW'(1);
          if (in_req_type == mba_pkg::REQ_LOAD) begin
            res_status_nxt = mba_pkg::ST_LOADED;
          end else if (active_cnt == '0) begin
            res_status_nxt = mba_pkg::ST_OOM;
          end
        end
      end
      mba_pkg::S_BACK: begin
        if (start_r < rd_data.base) begin
          if (e_r == '0) begin
            // Start lies below the first region: clamp to its base.
            start_nxt = rd_data.base;
          end else begin
            e_nxt = e_r - CW'(1);
          end
        end
      end
      mba_pkg::S_FWD_LIM: begin
        aligned_nxt    = aligned_calc;
        region_end_nxt = {1'b0, rd_data.base} + {1'b0, rd_data.length};
        if (lim_sum > mba_pkg::LIMIT_32) begin
          res_status_nxt = mba_pkg::ST_LIMIT;
        end
      end
      mba_pkg::S_FWD_FIT: begin
        if (fit_sum < region_end_r) begin
          res_end_nxt    = fit_sum[AW-1:0];
          res_status_nxt = mba_pkg::ST_OK;
        end else if (last_region) begin
          res_status_nxt = mba_pkg::ST_OOM;
        end else begin
          e_nxt = e_r + CW'(1);
        end
      end
      mba_pkg::S_FWD_NEXT: begin
        start_nxt = rd_data.base;
      end
      mba_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_end_nxt    = res_end_r;
          out_status_nxt = res_status_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= mba_pkg::S_IDLE;
      out_valid_r    <= 1'b0;
      region_count_r <= '0;
      e_r            <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      e_r         <= e_nxt;
      if (cfg_wr_en) begin
        region_count_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    start_r      <= start_nxt;
    size_r       <= size_nxt;
    aligned_r    <= aligned_nxt;
    region_end_r <= region_end_nxt;
    res_end_r    <= res_end_nxt;
    res_status_r <= res_status_nxt;
    out_end_r    <= out_end_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_end_address = out_end_r;
  assign out_status      = out_status_r;

  // A load request goes straight to the result stage with the loaded status.
  a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_req_type == mba_pkg::REQ_LOAD) |=>
      state_r == mba_pkg::S_DONE && res_status_r == mba_pkg::ST_LOADED)
    else $error("load request did not complete as loaded");

  // The walk never leaves the active part of the table.
  a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mba_pkg::S_BACK || state_r == mba_pkg::S_FWD_LIM ||
     state_r == mba_pkg::S_FWD_FIT || state_r == mba_pkg::S_FWD_NEXT) |->
      e_r < active_cnt)
    else $error("walk index beyond active region count");

  // The fit compare always sees a page-aligned start.
  a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mba_pkg::S_FWD_FIT |-> aligned_r[PW-1:0] == '0)
    else $error("start not page aligned at fit compare");

  // Only a successful allocation carries a nonzero end address.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != mba_pkg::ST_OK |-> out_end_r == '0)
    else $error("failed or load result carries an end address");

endmodule

>>> dv/memory_map_bump_allocator_tb.sv
// ----------------------------------------------------------------------------
// Memory map bump allocator testbench
// Loads region tables, issues allocation requests and checks each response
// against a cycle-free model of the region walk kept inside the bench.
// ----------------------------------------------------------------------------
module memory_map_bump_allocator_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SLOTS   = 16;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SEG_ITEMS   = 165;

  // One request as the bench sees it, every field present whether used or not.
  typedef struct {
    mba_pkg::req_t req_type;
    logic [3:0]    region_index;
    logic [35:0]   region_base;
    logic [35:0]   region_length;
    logic [35:0]   start_address;
    logic [31:0]   alloc_size;
  } region_req_t;

  // One response: the end of the granted block and how the walk ended.
  typedef struct {
    logic [35:0]      end_address;
    mba_pkg::status_t status;
  } grant_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [4:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_req_type = 1'b0;
  logic [3:0]  in_region_index = '0;
  logic [35:0] in_region_base = '0;
  logic [35:0] in_region_length = '0;
  logic [35:0] in_start_address = '0;
  logic [31:0] in_alloc_size = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [35:0] out_end_address;
  logic [1:0]  out_status;

  memory_map_bump_allocator #(
    .MAX_REGIONS(NUM_SLOTS)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_region_index (in_region_index),
    .in_region_base  (in_region_base),
    .in_region_length(in_region_length),
    .in_start_address(in_start_address),
    .in_alloc_size   (in_alloc_size),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_end_address (out_end_address),
    .out_status      (out_status)
  );

  // Requests waiting to be driven, and responses predicted but not yet seen.
  region_req_t request_q[$];
  grant_t      grant_q[$];

  // The bench's own copy of the region table and of region_count. They are
  // updated when the block accepts a request or a register write, so the
  // model always sees exactly what the hardware sees.
  logic [35:0] base_tbl [NUM_SLOTS];
  logic [35:0] len_tbl  [NUM_SLOTS];
  logic [4:0]  cfg_count = '0;

  // The layout most recently sent, used to aim allocations at regions and to reload its entries.
  logic [35:0] plan_base [NUM_SLOTS];
  logic [35:0] plan_len  [NUM_SLOTS];

  region_req_t cur_req;
  int send_idle_pct = 32;
  int recv_idle_pct = 50;
  int errors = 0;
  int cycle_count = 0;
  int n_loads = 0;
  int n_allocs = 0;
  int n_ok = 0;
  int n_oom = 0;
  int n_limit = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Model of the block. A load writes one slot. An allocation first walks
  // back from the last active region to the one whose base is not above the
  // start, clamping to the first base when the start lies below every
  // region. It then walks forward: the 4 GiB limit check comes first, then
  // page alignment, then the strict fit against the region end. A miss moves
  // the start to the next region's base.
  // --------------------------------------------------------------------------
  function automatic grant_t walk_regions(input region_req_t r);
    grant_t      g;
    logic [63:0] start;
    logic [63:0] size;
    logic [63:0] region_end;
    int          n;
    int          e;
    bit          done;
    g.end_address = '0;
    g.status      = mba_pkg::ST_LOADED;
    if (r.req_type == mba_pkg::REQ_LOAD) begin
      base_tbl[r.region_index] = r.region_base;
      len_tbl[r.region_index]  = r.region_length;
      return g;
    end
    // A count above the table size acts as a full table.
    n = (int'(cfg_count) > NUM_SLOTS) ? NUM_SLOTS : int'(cfg_count);
    g.status = mba_pkg::ST_OOM;
    if (n == 0) return g;
    start = 64'(r.start_address);
    size  = 64'(r.alloc_size);
    e     = n - 1;
    done  = 1'b0;
    while (!done && start < 64'(base_tbl[e])) begin
      if (e == 0) begin
        start = 64'(base_tbl[0]);
        done  = 1'b1;
      end else begin
        e--;
      end
    end
    done = 1'b0;
    while (!done) begin
      if (start + size > 64'(mba_pkg::LIMIT_32)) begin
        g.status = mba_pkg::ST_LIMIT;
        done     = 1'b1;
      end else begin
        if (start[11:0] != 12'h000) start = {start[63:12] + 52'd1, 12'h000};
        region_end = 64'(base_tbl[e]) + 64'(len_tbl[e]);
        if (start + size < region_end) begin
          g.end_address = 36'(start + size);
          g.status      = mba_pkg::ST_OK;
          done          = 1'b1;
        end else begin
          e++;
          if (e >= n) begin
            done = 1'b1;
          end else begin
            start = 64'(base_tbl[e]);
          end
        end
      end
    end
    return g;
  endfunction

  function automatic logic [35:0] rand36();
    return {4'($urandom_range(15)), 32'($urandom)};
  endfunction

  // Fields that a request type ignores are filled with random junk, so the
  // block is shown that it really does ignore them.
  function automatic region_req_t load_req(input logic [3:0] idx, input logic [35:0] base,
                                           input logic [35:0] len);
    region_req_t r;
    r.req_type      = mba_pkg::REQ_LOAD;
    r.region_index  = idx;
    r.region_base   = base;
    r.region_length = len;
    r.start_address = rand36();
    r.alloc_size    = $urandom;
    return r;
  endfunction

  function automatic region_req_t alloc_req(input logic [35:0] start, input logic [31:0] size);
    region_req_t r;
    r.req_type      = mba_pkg::REQ_ALLOC;
    r.region_index  = 4'($urandom_range(15));
    r.region_base   = rand36();
    r.region_length = rand36();
    r.start_address = start;
    r.alloc_size    = size;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver. A new request is presented only when the previous one
  // was taken or none was up; a stalled request holds its payload. The model
  // runs on the edge where the block accepts the request.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_requests
    region_req_t nxt;
    grant_t      g;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        g = walk_regions(cur_req);
        grant_q.push_back(g);
        if (cur_req.req_type == mba_pkg::REQ_LOAD) n_loads++;
        else n_allocs++;
        case (g.status)
          mba_pkg::ST_OK:    n_ok++;
          mba_pkg::ST_OOM:   n_oom++;
          mba_pkg::ST_LIMIT: n_limit++;
          default: ;
        endcase
      end
      if (!in_valid || !in_stall) begin
        if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = request_q.pop_front();
          cur_req          <= nxt;
          in_req_type      <= nxt.req_type;
          in_region_index  <= nxt.region_index;
          in_region_base   <= nxt.region_base;
          in_region_length <= nxt.region_length;
          in_start_address <= nxt.start_address;
          in_alloc_size    <= nxt.alloc_size;
          in_valid         <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Response monitor. Stall is drawn at random every cycle; each accepted
  // response is compared with the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_grants
    grant_t g;
    out_stall <= ($urandom_range(99) < recv_idle_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (grant_q.size() == 0) begin
        $display("%0t: response with nothing predicted, end %h status %0d", $time,
                 out_end_address, out_status);
        errors++;
      end else begin
        g = grant_q.pop_front();
        if (out_end_address !== g.end_address) begin
          $display("%0t: end_address mismatch, expected %h, actual %h", $time,
                   g.end_address, out_end_address);
          errors++;
        end
        if (out_status !== g.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                   g.status, out_status);
          errors++;
        end
      end
    end
  end

  // A hung block ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d responses outstanding", $time, grant_q.size());
      $display("memory_map_bump_allocator_tb failed");
      $finish;
    end
  end

  // Returns once every queued request was taken and every response came back.
  // Checking on the falling edge keeps clear of the rising-edge updates.
  task automatic wait_drained();
    @(negedge clk);
    while (request_q.size() != 0 || in_valid || grant_q.size() != 0) @(negedge clk);
  endtask

  // region_count is only written with the block idle, so no allocation in
  // flight can see a half-changed table size.
  task automatic set_region_count(input logic [4:0] value);
    wait_drained();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    cfg_count   <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Sends a fresh well-formed table: sixteen ascending regions below 4 GiB,
  // with a few bases off page boundaries and a few empty or tiny regions.
  task automatic load_layout();
    logic [35:0] cursor;
    logic [35:0] len;
    cursor = ($urandom_range(3) == 0) ? 36'h0 : 36'($urandom_range(32'h0100_0000));
    for (int i = 0; i < NUM_SLOTS; i++) begin
      case ($urandom_range(7))
        0:       len = 36'($urandom_range(32'h1000));
        1:       len = 36'h0;
        default: len = 36'($urandom_range(32'h0C00_0000));
      endcase
      plan_base[i] = cursor;
      plan_len[i]  = len;
      request_q.push_back(load_req(4'(i), cursor, len));
      cursor = cursor + len + 36'($urandom_range(32'h0200_0000));
    end
  endtask

  // One random segment. Most requests are allocations aimed at the loaded
  // regions; the rest are loads of random or planned values and allocations with arbitrary values.
  task automatic run_segment(input logic [4:0] count, input int items);
    int          pick;
    int          k;
    logic [35:0] start;
    logic [31:0] size;
    set_region_count(count);
    load_layout();
    for (int i = 0; i < items; i++) begin
      pick = $urandom_range(99);
      k    = $urandom_range(NUM_SLOTS - 1);
      if (pick < 10) begin
        request_q.push_back(load_req(4'(k), rand36(), rand36()));
      end else if (pick < 18) begin
        request_q.push_back(load_req(4'(k), plan_base[k], plan_len[k]));
      end else if (pick < 28) begin
        request_q.push_back(alloc_req(rand36(), $urandom));
      end else begin
        case ($urandom_range(9))
          0:       start = 36'($urandom_range(32'(plan_base[0])));
          1:       start = 36'h1_0000_0000 - 36'($urandom_range(32'h0001_0000));
          default: start = plan_base[k] + 36'($urandom_range(32'(plan_len[k])));
        endcase
        case ($urandom_range(9))
          0, 1, 2: size = $urandom_range(32'h0800_0000);
          3:       size = $urandom;
          default: size = $urandom_range(32'h0002_0000);
        endcase
        request_q.push_back(alloc_req(start, size));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence. Directed checks come first under the first idle mix, then
  // six random segments, two per idle mix, each with its own region_count.
  // Every change of region_count waits for the block to drain, which also
  // makes the sender pause until all responses are in.
  // --------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // With no regions every allocation runs out of memory without touching
    // the table. The extreme load goes to a slot that is rewritten below.
    request_q.push_back(alloc_req(36'h0, 32'h0));
    request_q.push_back(alloc_req(36'hF_FFFF_FFFF, 32'hFFFF_FFFF));
    request_q.push_back(load_req(4'd3, 36'hF_FFFF_FFFF, 36'hF_FFFF_FFFF));

    // Directed layout: region i starts at i * 256 MiB + 4 KiB, 128 MiB long.
    for (int i = 0; i < NUM_SLOTS; i++) begin
      plan_base[i] = 36'(i) * 36'h1000_0000 + 36'h1000;
      plan_len[i]  = 36'h0800_0000;
      request_q.push_back(load_req(4'(i), plan_base[i], plan_len[i]));
    end
    set_region_count(5'd16);

    // Start below the first base: clamped to it.
    request_q.push_back(alloc_req(36'h0, 32'h10));
    // Start in the gap before region 1: region 0 misses, region 1 fits.
    request_q.push_back(alloc_req(36'h1000_0800, 32'h100));
    // Start inside region 2, off page: aligned up.
    request_q.push_back(alloc_req(36'h2000_2345, 32'h10));
    // Exactly filling region 0 is not strictly below its end.
    request_q.push_back(alloc_req(36'h0000_1000, 32'h0800_0000));
    // Past 4 GiB before alignment.
    request_q.push_back(alloc_req(36'hFFFF_FFF0, 32'h100));
    // Landing exactly on 4 GiB passes the limit check but runs out of regions.
    request_q.push_back(alloc_req(36'hFFFF_F000, 32'h1000));
    // Largest size after clamping.
    request_q.push_back(alloc_req(36'h0, 32'hFFFF_FFFF));
    // Largest start with zero size.
    request_q.push_back(alloc_req(36'hF_FFFF_FFFF, 32'h0));
    // Filling the last region exactly: regions run out.
    request_q.push_back(alloc_req(36'hF000_1000, 32'h0800_0000));

    // A count above the table size acts as a full table.
    set_region_count(5'd31);
    request_q.push_back(alloc_req(36'h3000_0000, 32'h40));

    run_segment(5'd16, SEG_ITEMS);
    run_segment(5'd1, SEG_ITEMS);

    wait_drained();
    send_idle_pct = 50;
    recv_idle_pct = 32;
    run_segment(5'($urandom_range(15, 2)), SEG_ITEMS);
    run_segment(5'd17, SEG_ITEMS);

    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_segment(5'd0, SEG_ITEMS);
    run_segment(5'($urandom_range(16, 1)), SEG_ITEMS);

    // Let any stray response show up before the verdict.
    wait_drained();
    repeat (100) @(posedge clk);

    $display("Run covered %0d region loads and %0d allocations under three idle mixes.",
             n_loads, n_allocs);
    $display("Allocations granted %0d, out of memory %0d, over the 4 GiB limit %0d.",
             n_ok, n_oom, n_limit);
    if (errors == 0 && grant_q.size() == 0) begin
      $display("memory_map_bump_allocator_tb passed");
    end else begin
      $display("memory_map_bump_allocator_tb failed");
    end
    $finish;
  end

endmodule
